// ----- rtl/wptp_pkg.sv -----
// Shared types, character codes and marker tables for the word-processor text converter.
// Used by wptp_ctrl, wptp_datapath and word_processor_text_to_plain.
package wptp_pkg;

	localparam int TAB_STOP    = 8;
	localparam int MAX_COLUMN  = 255;
	localparam int MAX_RESULTS = 40;
	localparam int EMIT_LIMIT  = MAX_RESULTS - 1;
	localparam int ECNT_W      = $clog2(MAX_RESULTS);

	localparam logic [7:0] COL_MAX = 8'(MAX_COLUMN);

	localparam logic [6:0] CH_NUL         = 7'h00;
	localparam logic [6:0] CH_BOLD        = 7'h02;
	localparam logic [6:0] CH_TAB         = 7'h09;
	localparam logic [6:0] CH_NL          = 7'h0A;
	localparam logic [6:0] CH_CR          = 7'h0D;
	localparam logic [6:0] CH_UNDER       = 7'h13;
	localparam logic [6:0] CH_RAISE       = 7'h14;
	localparam logic [6:0] CH_LOWER       = 7'h16;
	localparam logic [6:0] CH_SOFT_HYPHEN = 7'h1F;
	localparam logic [6:0] CH_CTRL_LAST   = 7'h1F;
	localparam logic [6:0] CH_SPACE       = 7'h20;
	localparam logic [6:0] CH_DOT         = 7'h2E;
	localparam logic [6:0] CH_LT          = 7'h3C;
	localparam logic [6:0] CH_GT          = 7'h3E;
	localparam logic [6:0] CH_CARET       = 7'h5E;
	localparam logic [6:0] CH_USCORE      = 7'h5F;
	localparam logic [6:0] CH_DEL         = 7'h7F;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_TABS,
		ST_SPACES,
		ST_CHAR,
		ST_NEWLINE,
		ST_MARK
	} state_t;

	typedef enum logic [1:0] {
		CL_NONE,
		CL_NEWLINE,
		CL_MARK,
		CL_PRINT
	} cls_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_TAB,
		EM_SPACE,
		EM_CHAR,
		EM_NL,
		EM_MARK
	} emit_t;

	typedef enum logic [1:0] {
		MK_BOLD,
		MK_UNDER,
		MK_LOWER,
		MK_RAISE
	} mark_t;

	typedef struct packed {
		logic  load;
		logic  apply;
		emit_t emit;
	} cmd_t;

	typedef struct packed {
		cls_t cls;
		logic has_lay;
		logic tab_more;
		logic space_more;
		logic mark_final;
		logic slot_free;
	} status_t;

	function automatic logic [7:0] col_bump(input logic [7:0] col);
		return (col < COL_MAX) ? col + 8'd1 : col;
	endfunction

	function automatic logic [1:0] mark_len(input mark_t sel);
		return (sel == MK_BOLD) ? 2'd3 : 2'd2;
	endfunction

	function automatic logic [6:0] mark_char(input mark_t sel, input logic closing,
			input logic [1:0] idx);
		logic [6:0] ch;
		ch = CH_LT;
		case (sel)
			MK_BOLD, MK_LOWER: begin
				ch = closing ? CH_GT : CH_LT;
			end
			MK_UNDER: begin
				if (closing) ch = (idx == 2'd0) ? CH_USCORE : CH_GT;
				else         ch = (idx == 2'd0) ? CH_LT : CH_USCORE;
			end
			MK_RAISE: begin
				if (closing) ch = (idx == 2'd0) ? CH_CARET : CH_GT;
				else         ch = (idx == 2'd0) ? CH_LT : CH_CARET;
			end
			default: begin
				ch = CH_LT;
			end
		endcase
		return ch;
	endfunction

endpackage

// ----- rtl/word_processor_text_to_plain.sv -----
// Top level of the word-processor text to plain ASCII converter.
// Depends on wptp_pkg; instantiates wptp_ctrl and wptp_datapath.
//
// One byte is taken per item and turned into zero or more ASCII beats, the final beat of an
// item carrying last. The state machine handles one byte at a time: it accepts the byte, then
// decodes it. A byte that yields nothing, or one character launched into the output register
// while its slot is free, is done at decode; a marker then emits its characters, and a
// printable byte after a space run lays down tabs, spaces, then the character. The output
// register lets the next byte be accepted while the last beat waits; output stall holds beats.
module word_processor_text_to_plain (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       in_valid,
	output logic       in_stall,
	output logic [6:0] out_char,
	output logic       last,
	output logic       out_valid,
	input  logic       out_stall
);
	import wptp_pkg::*;

	cmd_t    cmd;
	status_t st;

	wptp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	wptp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_byte   (in_byte),
		.cmd       (cmd),
		.st        (st),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_char  (out_char),
		.last      (last)
	);

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit != EM_NONE |-> st.slot_free)
		else $error("beat launched over a held output");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall && cmd.apply)
		else $error("accepted byte not decoded next cycle");

	a_mark_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit == EM_MARK && st.mark_final |=> !in_stall)
		else $error("marker end did not release input");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit == EM_CHAR || cmd.emit == EM_NL) |=> out_valid && last && !in_stall)
		else $error("final beat not marked last");

endmodule

// ----- rtl/wptp_ctrl.sv -----
// Sequencing state machine of the text converter: input handshake and emit order.
// Depends on wptp_pkg; drives commands to wptp_datapath from its status.
module wptp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  wptp_pkg::status_t  st,
	output wptp_pkg::cmd_t     cmd
);
	import wptp_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		cmd.emit  = EM_NONE;
		in_stall  = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.apply = 1'b1;
				case (st.cls)
					CL_NONE: begin
						state_nxt = ST_IDLE;
					end
					CL_NEWLINE: begin
						if (st.slot_free) begin
							cmd.emit  = EM_NL;
							state_nxt = ST_IDLE;
						end else begin
							state_nxt = ST_NEWLINE;
						end
					end
					CL_MARK: begin
						state_nxt = ST_MARK;
					end
					CL_PRINT: begin
						if (st.has_lay) begin
							state_nxt = ST_TABS;
						end else if (st.slot_free) begin
							cmd.emit  = EM_CHAR;
							state_nxt = ST_IDLE;
						end else begin
							state_nxt = ST_CHAR;
						end
					end
					default: begin
						state_nxt = ST_IDLE;
					end
				endcase
			end
			ST_TABS: begin
				if (!st.tab_more) begin
					state_nxt = ST_SPACES;
				end else if (st.slot_free) begin
					cmd.emit = EM_TAB;
				end
			end
			ST_SPACES: begin
				if (!st.space_more) begin
					state_nxt = ST_CHAR;
				end else if (st.slot_free) begin
					cmd.emit = EM_SPACE;
				end
			end
			ST_CHAR: begin
				if (st.slot_free) begin
					cmd.emit  = EM_CHAR;
					state_nxt = ST_IDLE;
				end
			end
			ST_NEWLINE: begin
				if (st.slot_free) begin
					cmd.emit  = EM_NL;
					state_nxt = ST_IDLE;
				end
			end
			ST_MARK: begin
				if (st.slot_free) begin
					cmd.emit = EM_MARK;
					if (st.mark_final) state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/wptp_datapath.sv -----
// Datapath of the text converter: byte decode, column and toggle state, run counters, output beat.
// Depends on wptp_pkg; driven by commands from wptp_ctrl.
module wptp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [7:0]         in_byte,
	input  wptp_pkg::cmd_t     cmd,
	output wptp_pkg::status_t  st,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [6:0]         out_char,
	output logic               last
);
	import wptp_pkg::*;

	logic [7:0] byte_q;
	logic [7:0] col_q, pend_q;
	logic       bold_q, under_q, lower_q, raise_q;
	logic       gap_q, hyph_q, dir_q, wrap_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       last_q;
	logic [7:0] tab_cnt_q, space_cnt_q;
	logic [ECNT_W-1:0] ecount_q;
	mark_t      mark_sel_q;
	logic       mark_close_q;
	logic [1:0] mark_idx_q;

	logic [6:0] c;
	logic       soft_bit;
	cls_t       cls;
	logic [7:0] col_n, pend_n;
	logic       bold_n, under_n, lower_n, raise_n;
	logic       gap_n, hyph_n, dir_n, wrap_n;
	mark_t      msel;
	logic       mclose;
	logic [7:0] col1, pend1, lay_from, tabs_c, spaces_c;
	logic       room;
	logic       slot_free;

	assign c        = byte_q[6:0];
	assign soft_bit = byte_q[7];

	always_comb begin
		col1     = gap_q ? col_bump(col_q) : col_q;
		pend1    = gap_q ? 8'd1 : pend_q;
		lay_from = (pend1 > col1) ? 8'd0 : col1 - pend1;
		tabs_c   = '0;
		spaces_c = '0;
		if (pend1 != 8'd0) begin
			tabs_c   = 8'(col1 / TAB_STOP) - 8'(lay_from / TAB_STOP);
			spaces_c = (tabs_c == 8'd0) ? col1 - lay_from : 8'(col1 % TAB_STOP);
		end
	end

	always_comb begin
		cls     = CL_NONE;
		col_n   = col_q;
		pend_n  = pend_q;
		bold_n  = bold_q;
		under_n = under_q;
		lower_n = lower_q;
		raise_n = raise_q;
		gap_n   = gap_q;
		hyph_n  = hyph_q;
		dir_n   = dir_q;
		wrap_n  = wrap_q;
		msel    = MK_BOLD;
		mclose  = 1'b0;
		if (c == CH_CR) begin
			cls = CL_NONE;
		end else if (c == CH_NL) begin
			if (hyph_q) begin
				wrap_n = 1'b1;
				hyph_n = 1'b0;
			end else begin
				if (!dir_q) cls = CL_NEWLINE;
				col_n  = '0;
				pend_n = '0;
				dir_n  = 1'b0;
				wrap_n = 1'b0;
			end
		end else if (dir_q) begin
			cls = CL_NONE;
		end else if (c == CH_SPACE) begin
			if (!soft_bit) begin
				gap_n = 1'b0;
				if (col_q < COL_MAX) begin
					pend_n = pend_q + 8'd1;
					col_n  = col_q + 8'd1;
				end
				if (wrap_q) begin
					cls    = CL_NEWLINE;
					col_n  = '0;
					pend_n = '0;
					dir_n  = 1'b0;
					wrap_n = 1'b0;
				end
			end else begin
				gap_n = 1'b1;
			end
		end else if (c == CH_SOFT_HYPHEN) begin
			hyph_n = 1'b1;
		end else if (c == CH_DOT && col_q == 8'd0) begin
			dir_n = 1'b1;
		end else if (c == CH_BOLD) begin
			cls    = CL_MARK;
			msel   = MK_BOLD;
			mclose = bold_q;
			bold_n = !bold_q;
		end else if (c == CH_UNDER) begin
			cls     = CL_MARK;
			msel    = MK_UNDER;
			mclose  = under_q;
			under_n = !under_q;
		end else if (c == CH_LOWER) begin
			cls     = CL_MARK;
			msel    = MK_LOWER;
			mclose  = lower_q;
			lower_n = !lower_q;
		end else if (c == CH_RAISE) begin
			cls     = CL_MARK;
			msel    = MK_RAISE;
			mclose  = raise_q;
			raise_n = !raise_q;
		end else if (c inside {[CH_NUL:CH_CTRL_LAST], CH_DEL}) begin
			cls = CL_NONE;
		end else begin
			cls    = CL_PRINT;
			gap_n  = 1'b0;
			pend_n = '0;
			col_n  = col_bump(col1);
		end
	end

	assign room      = (ecount_q < ECNT_W'(EMIT_LIMIT));
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		st            = '0;
		st.cls        = cls;
		st.has_lay    = (tabs_c != 8'd0) || (spaces_c != 8'd0);
		st.tab_more   = (tab_cnt_q != 8'd0) && room;
		st.space_more = (space_cnt_q != 8'd0) && room;
		st.mark_final = (mark_idx_q == mark_len(mark_sel_q) - 2'd1);
		st.slot_free  = slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			pend_q      <= '0;
			bold_q      <= 1'b0;
			under_q     <= 1'b0;
			lower_q     <= 1'b0;
			raise_q     <= 1'b0;
			gap_q       <= 1'b0;
			hyph_q      <= 1'b0;
			dir_q       <= 1'b0;
			wrap_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				col_q   <= col_n;
				pend_q  <= pend_n;
				bold_q  <= bold_n;
				under_q <= under_n;
				lower_q <= lower_n;
				raise_q <= raise_n;
				gap_q   <= gap_n;
				hyph_q  <= hyph_n;
				dir_q   <= dir_n;
				wrap_q  <= wrap_n;
			end
			if (cmd.emit != EM_NONE) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) byte_q <= in_byte;
		if (cmd.apply) begin
			tab_cnt_q    <= tabs_c;
			space_cnt_q  <= spaces_c;
			ecount_q     <= '0;
			mark_sel_q   <= msel;
			mark_close_q <= mclose;
			mark_idx_q   <= '0;
		end
		case (cmd.emit)
			EM_TAB: begin
				out_char_q <= CH_TAB;
				last_q     <= 1'b0;
				tab_cnt_q  <= tab_cnt_q - 8'd1;
				ecount_q   <= ecount_q + 1'b1;
			end
			EM_SPACE: begin
				out_char_q  <= CH_SPACE;
				last_q      <= 1'b0;
				space_cnt_q <= space_cnt_q - 8'd1;
				ecount_q    <= ecount_q + 1'b1;
			end
			EM_CHAR: begin
				out_char_q <= c;
				last_q     <= 1'b1;
			end
			EM_NL: begin
				out_char_q <= CH_NL;
				last_q     <= 1'b1;
			end
			EM_MARK: begin
				out_char_q <= mark_char(mark_sel_q, mark_close_q, mark_idx_q);
				last_q     <= st.mark_final;
				mark_idx_q <= mark_idx_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last      = last_q;

endmodule
